FILE: hw/rtl/bcd_datetime_minus_offset_top_defines.svh
// Assertion macros for the BCD date/time minus offset block.
// Used by bcd_datetime_minus_offset_top; expects clk and arst_n in scope.
`ifndef BCD_DATETIME_MINUS_OFFSET_TOP_DEFINES_SVH
`define BCD_DATETIME_MINUS_OFFSET_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BDMO_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("bdmo assertion failed");
`define BDMO_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("bdmo assertion failed");
`else
`define BDMO_ASSERT_NEXT(label, pre, post)
`define BDMO_ASSERT_SAME(label, pre, post)
`endif

`endif

FILE: hw/rtl/bdmo_pkg.sv
// Shared types, register indexes and BCD/calendar helpers for the
// BCD date/time minus offset block. No dependencies.
`default_nettype none

package bdmo_pkg;

	typedef enum logic [1:0] {
		CFG_OFFSET_DAYS    = 2'd0,
		CFG_OFFSET_HOURS   = 2'd1,
		CFG_OFFSET_MINUTES = 2'd2,
		CFG_OFFSET_SECONDS = 2'd3
	} cfg_index_t;

	localparam logic [7:0] BCD_BAD = 8'hff;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [6:0] day;
		logic [7:0] hour;
		logic [7:0] minute;
		logic [7:0] second;
		logic       bad;
	} dec_t;

	function automatic logic [7:0] bcd_value(input logic [7:0] b);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = {4'd0, b[7:4]};
		lo = {4'd0, b[3:0]};
		if (b >= 8'ha0 || lo >= 8'd10) begin
			return BCD_BAD;
		end
		return (hi << 3) + (hi << 1) + lo;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] month);
		logic [8:0] d;
		unique case (month)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bdmo_decode.sv
// First pipeline stage: BCD decode of one clock reading and date check.
// Depends on bdmo_pkg.
`default_nettype none

module bdmo_decode (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          in_valid,
	input  wire logic [7:0]    year_bcd,
	input  wire logic [7:0]    month_bcd,
	input  wire logic [7:0]    day_bcd,
	input  wire logic [7:0]    hour_bcd,
	input  wire logic [7:0]    minute_bcd,
	input  wire logic [7:0]    second_bcd,
	output logic               v_s1,
	output bdmo_pkg::dec_t     dec_s1
);
	import bdmo_pkg::*;

	logic [7:0] year_v;
	logic [7:0] month_v;
	logic [7:0] day_v;
	dec_t       dec_d;

	always_comb begin
		year_v  = bcd_value(year_bcd);
		month_v = bcd_value(month_bcd);
		day_v   = bcd_value(day_bcd);
		dec_d.bad    = (year_v == BCD_BAD) || (day_v == BCD_BAD) ||
			(month_v == 8'd0) || (month_v > 8'd12);
		dec_d.year   = year_v[6:0];
		dec_d.month  = month_v[3:0];
		dec_d.day    = day_v[6:0];
		dec_d.hour   = bcd_value(hour_bcd);
		dec_d.minute = bcd_value(minute_bcd);
		dec_d.second = bcd_value(second_bcd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s1 <= dec_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bcd_datetime_minus_offset_top.sv
// Top level: BCD clock reading to day number, minus a configured offset.
// Depends on bdmo_pkg, bdmo_decode and bcd_datetime_minus_offset_top_defines.svh.
//
//  channel  direction  handshake              word
//  in       sink       in_valid / in_stall    year..second BCD
//  out      source     out_valid / out_stall  days/hours/minutes/seconds, bad_date
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Three register stages (decode, day count and raw subtract, borrow);
// one word per cycle sustained while the output is not stalled.
// All stages hold together while out_valid is high and out_stall is high.
// Reset clears the stage valid bits and the offsets to zero.
// cfg_ready is always high.
`default_nettype none
`include "bcd_datetime_minus_offset_top_defines.svh"

module bcd_datetime_minus_offset_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         year_bcd,
	input  wire logic [7:0]         month_bcd,
	input  wire logic [7:0]         day_bcd,
	input  wire logic [7:0]         hour_bcd,
	input  wire logic [7:0]         minute_bcd,
	input  wire logic [7:0]         second_bcd,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      days_out,
	output logic signed [7:0]       hours_out,
	output logic signed [7:0]       minutes_out,
	output logic signed [7:0]       seconds_out,
	output logic                    bad_date,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire bdmo_pkg::cfg_index_t cfg_index,
	input  wire logic [15:0]        cfg_data
);
	import bdmo_pkg::*;

	logic        adv;
	logic [15:0] off_days_q;
	logic [7:0]  off_hours_q;
	logic [7:0]  off_minutes_q;
	logic [7:0]  off_seconds_q;

	logic        v_s1;
	dec_t        dec_s1;

	logic        v_s2;
	logic        bad_s2;
	logic [15:0] count_s2;
	logic [7:0]  h_s2;
	logic [7:0]  m_s2;
	logic [7:0]  s_s2;

	logic        v_s3;
	logic        bad_s3;
	logic [15:0] d_s3;
	logic [7:0]  h_s3;
	logic [7:0]  m_s3;
	logic [7:0]  s_s3;

	logic [6:0]  ym1;
	logic [15:0] year_days;
	logic [15:0] count_d;

	logic        s_neg;
	logic        m_neg;
	logic        h_neg;
	logic [7:0]  s_fix;
	logic [7:0]  m_sub;
	logic [7:0]  m_fix;
	logic [7:0]  h_sub;
	logic [7:0]  h_fix;
	logic [15:0] d_fix;

	assign adv       = !(v_s3 && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_days_q    <= '0;
			off_hours_q   <= '0;
			off_minutes_q <= '0;
			off_seconds_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OFFSET_DAYS:    off_days_q    <= cfg_data;
				CFG_OFFSET_HOURS:   off_hours_q   <= cfg_data[7:0];
				CFG_OFFSET_MINUTES: off_minutes_q <= cfg_data[7:0];
				CFG_OFFSET_SECONDS: off_seconds_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	bdmo_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (in_valid),
		.year_bcd   (year_bcd),
		.month_bcd  (month_bcd),
		.day_bcd    (day_bcd),
		.hour_bcd   (hour_bcd),
		.minute_bcd (minute_bcd),
		.second_bcd (second_bcd),
		.v_s1       (v_s1),
		.dec_s1     (dec_s1)
	);

	always_comb begin
		ym1       = dec_s1.year - 7'd1;
		year_days = '0;
		if (dec_s1.year != 7'd0) begin
			year_days = ({9'd0, ym1} * 16'd365) + {11'd0, ym1[6:2]};
		end
		count_d = year_days + {7'd0, days_before(dec_s1.month)} + {9'd0, dec_s1.day};
		if (dec_s1.month > 4'd2 && dec_s1.year[1:0] == 2'd0) begin
			count_d = count_d + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s2   <= dec_s1.bad;
			count_s2 <= count_d;
			h_s2     <= dec_s1.hour - off_hours_q;
			m_s2     <= dec_s1.minute - off_minutes_q;
			s_s2     <= dec_s1.second - off_seconds_q;
		end
	end

	always_comb begin
		s_neg = s_s2[7];
		s_fix = s_neg ? s_s2 + 8'd60 : s_s2;
		m_sub = m_s2 - {7'd0, s_neg};
		m_neg = m_sub[7];
		m_fix = m_neg ? m_sub + 8'd60 : m_sub;
		h_sub = h_s2 - {7'd0, m_neg};
		h_neg = h_sub[7];
		h_fix = h_neg ? h_sub + 8'd24 : h_sub;
		d_fix = count_s2 - off_days_q - {15'd0, h_neg};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s3 <= bad_s2;
			d_s3   <= bad_s2 ? '0 : d_fix;
			h_s3   <= bad_s2 ? '0 : h_fix;
			m_s3   <= bad_s2 ? '0 : m_fix;
			s_s3   <= bad_s2 ? '0 : s_fix;
		end
	end

	assign out_valid   = v_s3;
	assign bad_date    = bad_s3;
	assign days_out    = d_s3;
	assign hours_out   = h_s3;
	assign minutes_out = m_s3;
	assign seconds_out = s_s3;

	`BDMO_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, v_s1)
	`BDMO_ASSERT_NEXT(a_s2_reaches_out, v_s2 && !in_stall, out_valid)
	`BDMO_ASSERT_SAME(a_bad_zero, out_valid && bad_date,
		days_out == 16'sd0 && hours_out == 8'sd0 && minutes_out == 8'sd0 &&
		seconds_out == 8'sd0)

endmodule

`default_nettype wire

FILE: verif/bcd_datetime_minus_offset_top_tb.sv
// Self-checking bench for bcd_datetime_minus_offset_top: directed and random BCD readings
// under several offset settings, with random idle on input and output.
// Depends on bdmo_pkg and the block's RTL only.
`default_nettype none

module bcd_datetime_minus_offset_top_tb;
	import bdmo_pkg::*;

	localparam int STUCK_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] year;
		logic [7:0] month;
		logic [7:0] day;
		logic [7:0] hour;
		logic [7:0] minute;
		logic [7:0] second;
	} reading_t;

	typedef struct packed {
		logic [15:0] days;
		logic [7:0]  hours;
		logic [7:0]  minutes;
		logic [7:0]  seconds;
		logic        bad;
	} clock_result_t;

	class offset_scoreboard;
		logic [15:0] off_days;
		logic [7:0] off_hours;
		logic [7:0] off_minutes;
		logic [7:0] off_seconds;
		clock_result_t expected_q[$];
		int failures;

		function new();
			off_days = '0;
			off_hours = '0;
			off_minutes = '0;
			off_seconds = '0;
			failures = 0;
		endfunction

		function void set_offset(cfg_index_t idx, logic [15:0] data);
			case (idx)
				CFG_OFFSET_DAYS:    off_days = data;
				CFG_OFFSET_HOURS:   off_hours = data[7:0];
				CFG_OFFSET_MINUTES: off_minutes = data[7:0];
				CFG_OFFSET_SECONDS: off_seconds = data[7:0];
				default: ;
			endcase
		endfunction

		function int unsigned bcd_digits(logic [7:0] b);
			if (b >= 8'ha0 || b[3:0] > 4'd9) return 255;
			return b[7:4] * 10 + b[3:0];
		endfunction

		function int unsigned month_start(int unsigned mo);
			case (mo)
				1: return 0;
				2: return 31;
				3: return 59;
				4: return 90;
				5: return 120;
				6: return 151;
				7: return 181;
				8: return 212;
				9: return 243;
				10: return 273;
				11: return 304;
				default: return 334;
			endcase
		endfunction

		function void note_reading(reading_t r);
			int unsigned yr, mo, dy, count;
			clock_result_t e;
			yr = bcd_digits(r.year);
			mo = bcd_digits(r.month);
			dy = bcd_digits(r.day);
			e = '0;
			if (yr == 255 || mo == 255 || dy == 255 || mo < 1 || mo > 12) begin
				e.bad = 1'b1;
			end else begin
				count = 0;
				if (yr >= 1) count = 365 * (yr - 1) + (yr - 1) / 4;
				count += month_start(mo);
				if (mo > 2 && yr % 4 == 0) count += 1;
				count += dy;
				e.seconds = 8'(bcd_digits(r.second) - off_seconds);
				e.minutes = 8'(bcd_digits(r.minute) - off_minutes);
				e.hours = 8'(bcd_digits(r.hour) - off_hours);
				e.days = 16'(count - off_days);
				if (e.seconds[7]) begin
					e.seconds = e.seconds + 8'd60;
					e.minutes = e.minutes - 8'd1;
				end
				if (e.minutes[7]) begin
					e.minutes = e.minutes + 8'd60;
					e.hours = e.hours - 8'd1;
				end
				if (e.hours[7]) begin
					e.hours = e.hours + 8'd24;
					e.days = e.days - 16'd1;
				end
			end
			expected_q.push_back(e);
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$display("%0t %s expected %0d actual %0d", $time, name, want, got);
				failures++;
			end
		endfunction

		function void check_result(clock_result_t got);
			clock_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result word", $time);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("days_out", $signed(want.days), $signed(got.days));
			compare_field("hours_out", $signed(want.hours), $signed(got.hours));
			compare_field("minutes_out", $signed(want.minutes), $signed(got.minutes));
			compare_field("seconds_out", $signed(want.seconds), $signed(got.seconds));
			compare_field("bad_date", longint'(want.bad), longint'(got.bad));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] year_bcd;
	logic [7:0] month_bcd;
	logic [7:0] day_bcd;
	logic [7:0] hour_bcd;
	logic [7:0] minute_bcd;
	logic [7:0] second_bcd;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] days_out;
	logic signed [7:0] hours_out;
	logic signed [7:0] minutes_out;
	logic signed [7:0] seconds_out;
	logic bad_date;
	logic cfg_valid;
	logic cfg_ready;
	cfg_index_t cfg_index;
	logic [15:0] cfg_data;

	offset_scoreboard sb;
	bit quiet;
	int stuck_cycles;
	int sink_left;

	bcd_datetime_minus_offset_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.year_bcd(year_bcd),
		.month_bcd(month_bcd),
		.day_bcd(day_bcd),
		.hour_bcd(hour_bcd),
		.minute_bcd(minute_bcd),
		.second_bcd(second_bcd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.days_out(days_out),
		.hours_out(hours_out),
		.minutes_out(minutes_out),
		.seconds_out(seconds_out),
		.bad_date(bad_date),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [7:0] to_bcd(int unsigned n);
		return {4'(n / 10), 4'(n % 10)};
	endfunction

	function automatic logic [7:0] time_field(int unsigned top);
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick == 0) return 8'($urandom);
		if (pick == 1) return to_bcd($urandom_range(0, 99));
		return to_bcd($urandom_range(0, top));
	endfunction

	function automatic reading_t random_reading();
		reading_t r;
		int unsigned kind;
		kind = $urandom_range(0, 19);
		r.year = to_bcd($urandom_range(0, 99));
		r.month = to_bcd($urandom_range(1, 12));
		r.day = ($urandom_range(0, 9) == 0) ? to_bcd($urandom_range(0, 39))
			: to_bcd($urandom_range(1, 31));
		r.hour = time_field(23);
		r.minute = time_field(59);
		r.second = time_field(59);
		if (kind < 2) begin
			r = reading_t'({$urandom, 16'($urandom)});
		end else if (kind == 2) begin
			case ($urandom_range(0, 2))
				0: r.year = 8'($urandom);
				1: r.month = 8'($urandom);
				default: r.day = 8'($urandom);
			endcase
		end
		return r;
	endfunction

	function automatic logic [15:0] pad_byte(logic [7:0] v);
		if ($urandom_range(0, 3) == 0) return {8'($urandom), v};
		return {{8{v[7]}}, v};
	endfunction

	// hold the word until accepted; valid stays high for a follow-on word
	task automatic feed(reading_t r);
		int gap;
		in_valid <= 1'b1;
		year_bcd <= r.year;
		month_bcd <= r.month;
		day_bcd <= r.day;
		hour_bcd <= r.hour;
		minute_bcd <= r.minute;
		second_bcd <= r.second;
		do @(posedge clk); while (in_stall);
		gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic run_random(int count);
		repeat (count) feed(random_reading());
		in_valid <= 1'b0;
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// drain the pipe before touching the offsets
	task automatic set_offsets(logic [15:0] d, logic [7:0] h, logic [7:0] m, logic [7:0] s);
		do @(posedge clk); while (sb.pending() != 0);
		repeat (6) @(posedge clk);
		write_reg(CFG_OFFSET_DAYS, d);
		write_reg(CFG_OFFSET_HOURS, pad_byte(h));
		write_reg(CFG_OFFSET_MINUTES, pad_byte(m));
		write_reg(CFG_OFFSET_SECONDS, pad_byte(s));
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (sink_left != 0) begin
			sink_left--;
		end else if (quiet || $urandom_range(0, 2) != 0) begin
			out_stall <= 1'b0;
			sink_left = $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b1;
			sink_left = idle_len() - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			sb.note_reading({year_bcd, month_bcd, day_bcd, hour_bcd, minute_bcd, second_bcd});
		end
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result({days_out, hours_out, minutes_out, seconds_out, bad_date});
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			sb.set_offset(cfg_index, cfg_data);
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("bcd_datetime_minus_offset_top: mismatch");
			$finish;
		end
	end

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		year_bcd = '0;
		month_bcd = '0;
		day_bcd = '0;
		hour_bcd = '0;
		minute_bcd = '0;
		second_bcd = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_OFFSET_DAYS;
		cfg_data = '0;
		quiet = 1'b0;
		stuck_cycles = 0;
		sink_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		feed(48'h00_01_01_00_00_00);
		feed(48'h01_01_01_00_00_00);
		feed(48'h04_02_29_12_30_30);
		feed(48'h04_03_01_00_00_00);
		feed(48'h99_12_31_23_59_59);
		feed(48'hA0_01_01_00_00_00);
		feed(48'h1A_01_01_00_00_00);
		feed(48'h00_00_01_00_00_00);
		feed(48'h00_13_01_00_00_00);
		feed(48'h00_0A_01_00_00_00);
		feed(48'h00_01_3A_00_00_00);
		feed(48'h00_01_00_00_00_00);
		feed(48'h00_02_99_00_00_00);
		feed(48'hFF_FF_FF_FF_FF_FF);
		run_random(55);

		set_offsets(16'h0001, 8'h01, 8'h01, 8'h01);
		feed(48'h00_01_01_00_00_00);
		feed(48'h00_01_01_FF_FF_FF);
		feed(48'h00_01_01_23_59_59);
		feed(48'h00_01_01_99_99_99);
		feed(48'h50_06_15_00_00_5A);
		run_random(55);

		set_offsets(16'h7fff, 8'h7f, 8'h7f, 8'h7f);
		run_random(65);
		set_offsets(16'h8000, 8'h80, 8'h80, 8'h80);
		run_random(65);
		set_offsets(16'($urandom_range(0, 18000)) - 16'd9000,
			8'($urandom_range(0, 47)) - 8'd23,
			8'($urandom_range(0, 119)) - 8'd59,
			8'($urandom_range(0, 119)) - 8'd59);
		run_random(65);
		set_offsets(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		run_random(65);
		quiet = 1'b1;
		set_offsets(16'($urandom_range(0, 400)), 8'($urandom_range(0, 23)),
			8'($urandom_range(0, 59)), 8'($urandom_range(0, 59)));
		run_random(60);

		do @(posedge clk); while (sb.pending() != 0);
		repeat (8) @(posedge clk);
		if (sb.failures == 0)
			$display("bcd_datetime_minus_offset_top: match");
		else
			$display("bcd_datetime_minus_offset_top: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
